FILE: sv/sapc_pkg.sv
`default_nettype none
package sapc_pkg;
  localparam int unsigned SNAP_DIST  = 51200;
  localparam int unsigned HOLD_ANGLE = 68224;
  localparam int unsigned FAR_LIMIT  = 51200;
  localparam int unsigned NEAR_LIMIT = 25600;
  localparam int unsigned FULL_TURN  = 92160;
  localparam int unsigned SMALL_ERR  = 2560;
  localparam int unsigned LATCH_DIST = 512;
  localparam int unsigned READY_DIST = 512;

  localparam logic signed [7:0] MODE_STOP    = -8'sd1;
  localparam logic signed [7:0] MODE_PARK    = 8'sd99;
  localparam logic signed [7:0] MODE_ONE     = 8'sd1;
  localparam logic signed [7:0] MODE_SLOW    = 8'sd12;
  localparam logic signed [7:0] MODE_RETRACT = 8'sd13;

  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_MICROSTEP = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the input item
    logic sample;   // write the sample into the history
    logic average;  // sum the history and register the average
    logic control;  // evaluate the control law and error
    logic mult;     // form the proportional term
    logic finish;   // multiply by the microstep factor, then scale, clamp and update the state
  } sapc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sample_valid;
    logic sum_done;
  } sapc_status_t;
endpackage
`default_nettype wire

FILE: sv/sapc_datapath.sv
`default_nettype none
module sapc_datapath #(
  parameter int unsigned FILTER_DEPTH = 5,
  parameter int unsigned DWELL_MS     = 1000
) (
  input  wire                   clk,
  input  wire                   rst,
  input  sapc_pkg::sapc_cmd_t   cmd,
  output sapc_pkg::sapc_status_t status,
  input  wire [11:0]            tolerance,
  input  wire [8:0]             microstep_factor,
  input  wire signed [7:0]      mode,
  input  wire [16:0]            swing_target,
  input  wire                   halt,
  input  wire                   sample_valid,
  input  wire [11:0]            encoder_raw,
  input  wire [31:0]            now_ms,
  output logic signed [21:0]    swing_speed,
  output logic                  at_target,
  output logic                  task_complete,
  output logic [16:0]           filtered_angle
);
  import sapc_pkg::*;

  localparam int IW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int SW = 17 + $clog2(FILTER_DEPTH + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(FILTER_DEPTH - 1);
  // Reciprocal of the filter depth, exact for every history sum.
  localparam int RK = SW + 4;
  localparam logic [RK:0] AVG_RECIP =
    (RK+1)'(((64'd1 << RK) + 64'(FILTER_DEPTH) - 64'd1) / 64'(FILTER_DEPTH));
  // Reciprocal of five; together with a shift by 7 it divides by 640.
  localparam logic [23:0] SLOW_RECIP = 24'd13421773;

  // Captured item.
  logic signed [7:0] r_mode;
  logic [16:0] r_target;
  logic r_halt, r_valid;
  logic [11:0] r_raw;
  logic [31:0] r_now;

  // State.
  logic [16:0] hist [FILTER_DEPTH];
  logic [IW-1:0] hidx;
  logic [16:0] smoothed;
  logic latch;
  logic signed [17:0] latched_target;
  logic signed [7:0] latched_mode, previous_mode;
  logic dwell_started, retract_started;
  logic [31:0] dwell_start_time, retract_start_time;
  logic signed [18:0] last_error;
  logic signed [21:0] last_speed;

  // Summation walk and work registers.
  logic [SW-1:0] sum;
  logic [IW:0] sum_cnt;
  logic signed [18:0] err;
  logic [8:0] m_eff;
  logic slow;
  logic run_speed;
  logic signed [23:0] n_val;
  logic signed [31:0] prod;
  logic latch_w, ds_w, rs_w;
  logic [31:0] dst_w, rst_w;
  logic signed [17:0] lt_w;
  logic signed [7:0] lm_w;

  // Sample conversion and snap test.
  logic [16:0] conv;
  logic [IW-1:0] prev_i;
  logic signed [17:0] sdiff;
  logic snap;
  assign conv   = 17'(({6'd0, r_raw} * 18'd45 + 18'd1) >> 1);
  assign prev_i = (hidx == '0) ? LAST_IDX : hidx - IW'(1);
  assign sdiff  = $signed({1'b0, conv}) - $signed({1'b0, hist[prev_i]});
  assign snap   = (sdiff > 18'sd51200) || (sdiff < -18'sd51200);

  // Average of the history by reciprocal multiplication.
  logic [SW+RK:0] avg_prod;
  assign avg_prod = (SW+RK+1)'(sum) * (SW+RK+1)'(AVG_RECIP);

  // Control combinational logic, using the registered average.
  logic signed [17:0] sm, tgt, eff;
  logic signed [18:0] dlat, e0;
  logic dw_run, rt_run, run_ctrl, stop_m;
  logic [31:0] del_d, del_r;
  logic d_st, r_st;
  logic [31:0] d_t, r_t;
  logic signed [18:0] sdh;
  logic signed [18:0] ae;
  logic newlat;
  always_comb begin
    sm = $signed({1'b0, smoothed});
    tgt = $signed({1'b0, r_target});
    stop_m = (r_mode == MODE_STOP) || (r_mode == MODE_PARK);
    run_ctrl = !stop_m && !r_halt;
    dlat = 19'(tgt) - 19'(latched_target);
    newlat = (dlat > 19'sd512) || (dlat < -19'sd512) || (r_mode != latched_mode);
    sdh = 19'(sm) - 19'sd68224;
    d_st = dwell_started;
    d_t = dwell_start_time;
    if (r_mode == MODE_SLOW) begin
      if ((sdh < $signed({7'd0, tolerance})) && (-sdh < $signed({7'd0, tolerance}))
          && !dwell_started) begin
        d_st = 1'b1;
        d_t = r_now;
      end
    end else begin
      d_st = 1'b0;
    end
    r_st = retract_started;
    r_t = retract_start_time;
    if (r_mode == MODE_RETRACT) begin
      if (!retract_started) begin
        r_st = 1'b1;
        r_t = r_now;
      end
    end else begin
      r_st = 1'b0;
    end
    del_d = r_now - d_t;
    del_r = r_now - r_t;
    dw_run = (r_mode == MODE_SLOW) && d_st && (del_d < 32'(DWELL_MS));
    rt_run = (r_mode == MODE_RETRACT) && (del_r < 32'(DWELL_MS));
    eff = (dw_run || rt_run) ? sm : tgt;
    if (eff > 18'sd51200 && sm < 18'sd25600)
      e0 = 19'(eff) - 19'sd92160 - 19'(sm);
    else if (eff < 18'sd25600 && sm > 18'sd51200)
      e0 = 19'(eff) + 19'sd92160 - 19'(sm);
    else
      e0 = 19'(eff) - 19'(sm);
    ae = (e0 < 0) ? -e0 : e0;
  end

  // Small-error offset and proportional term.
  logic signed [18:0] aerr;
  logic signed [23:0] kk, n_next;
  assign aerr = (err < 0) ? -err : err;
  always_comb begin
    kk = (aerr < 19'sd2560) ? 24'(aerr) * 24'sd18 : 24'sd46080;
    n_next = 24'(err) * 24'sd55 + ((err > 0) ? kk : -kk);
  end

  // Scaling: magnitude of the product, truncated quotient.
  logic [30:0] aprod;
  logic [23:0] q_shift, q, q_r;
  logic [47:0] q_mul;
  always_comb begin
    aprod = prod[31] ? 31'(-prod) : 31'(prod);
    q_shift = aprod[30:7];
    q_mul = 48'(q_shift) * 48'(SLOW_RECIP);
    q = slow ? 24'(q_mul >> 26) : q_shift;
  end

  // Sign and clamp on the registered quotient.
  logic signed [21:0] lim, s_val;
  always_comb begin
    lim = slow ? 22'(m_eff) * 22'sd100 : 22'(m_eff) * 22'sd7000;
    s_val = prod[31] ? -22'(q_r) : 22'(q_r);
    if (q_r > 24'(lim)) s_val = prod[31] ? -lim : lim;
  end

  assign status.sample_valid = r_valid;
  assign status.sum_done = (sum_cnt == (IW+1)'(FILTER_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILTER_DEPTH; i++) hist[i] <= '0;
      hidx <= '0;
      smoothed <= '0;
      sum_cnt <= '0;
      sum <= '0;
    end else begin
      if (cmd.load) begin
        r_mode <= mode;
        r_target <= swing_target;
        r_halt <= halt;
        r_valid <= sample_valid;
        r_raw <= encoder_raw;
        r_now <= now_ms;
        sum <= '0;
        sum_cnt <= '0;
      end
      if (cmd.sample) begin
        for (int i = 0; i < FILTER_DEPTH; i++)
          if (snap || IW'(i) == hidx) hist[i] <= conv;
        hidx <= (hidx == LAST_IDX) ? '0 : hidx + IW'(1);
      end
      if (cmd.average && !status.sum_done) begin
        sum <= sum + SW'(hist[sum_cnt[IW-1:0]]);
        sum_cnt <= sum_cnt + 1'b1;
      end
      if (cmd.average && status.sum_done)
        smoothed <= 17'(avg_prod >> RK);
      if (cmd.control) begin
        err <= e0;
        slow <= (r_mode == MODE_SLOW);
        m_eff <= (microstep_factor > 9'd256) ? 9'd256 : microstep_factor;
        latch_w <= newlat ? 1'b0 : latch;
        lt_w <= newlat ? tgt : latched_target;
        lm_w <= newlat ? r_mode : latched_mode;
        ds_w <= d_st;
        dst_w <= d_t;
        rs_w <= r_st;
        rst_w <= r_t;
        run_speed <= run_ctrl && !(newlat ? 1'b0 : latch)
                     && (ae > $signed({7'd0, tolerance}));
      end
      if (cmd.mult) begin
        n_val <= n_next;
        prod <= '0;
      end
      if (cmd.finish) begin
        prod <= 32'(n_val) * $signed({1'b0, m_eff});
      end
    end
  end

  // Dwell test on the state that holds after this tick.
  logic fin_d, fin_d2;
  logic dw_fin;
  logic lat_fin;
  logic dsf, rsf;
  logic [31:0] dtf, rtf;
  logic signed [18:0] aerr_fin;
  always_comb begin
    dsf = run_ctrl ? ds_w : dwell_started;
    dtf = run_ctrl ? dst_w : dwell_start_time;
    rsf = run_ctrl ? rs_w : retract_started;
    rtf = run_ctrl ? rst_w : retract_start_time;
    dw_fin = ((r_mode == MODE_SLOW) && dsf && ((r_now - dtf) < 32'(DWELL_MS))) ||
             ((r_mode == MODE_RETRACT) && rsf && ((r_now - rtf) < 32'(DWELL_MS)));
    lat_fin = latch_w;
    if (run_ctrl && !latch_w && !run_speed && !dw_fin) lat_fin = 1'b1;
    aerr_fin = run_ctrl ? aerr : ((last_error < 0) ? -last_error : last_error);
  end

  // The quotient is registered first; the state update follows in the cycle after.
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_d <= 1'b0;
      fin_d2 <= 1'b0;
      latch <= 1'b0;
      latched_target <= -18'sd256;
      latched_mode <= MODE_STOP;
      previous_mode <= MODE_STOP;
      dwell_started <= 1'b0;
      retract_started <= 1'b0;
      dwell_start_time <= '0;
      retract_start_time <= '0;
      last_error <= '0;
      last_speed <= '0;
    end else begin
      fin_d <= cmd.finish;
      fin_d2 <= fin_d;
      if (fin_d) q_r <= q;
      if (fin_d2) begin
        if (run_ctrl) begin
          latch <= lat_fin;
          latched_target <= lt_w;
          latched_mode <= lm_w;
          dwell_started <= ds_w;
          dwell_start_time <= dst_w;
          retract_started <= rs_w;
          retract_start_time <= rst_w;
          last_error <= err;
          last_speed <= run_speed ? s_val : '0;
        end else if (stop_m || (r_mode == MODE_ONE && r_halt)) begin
          last_speed <= '0;
        end
        previous_mode <= r_mode;
        swing_speed <= run_ctrl ? (run_speed ? s_val : '0)
                       : ((stop_m || (r_mode == MODE_ONE && r_halt)) ? '0 : last_speed);
        at_target <= run_ctrl ? lat_fin : latch;
        task_complete <= (r_mode != previous_mode) ? 1'b0 :
                         (((aerr_fin <= 19'sd512) && !dw_fin) || (run_ctrl ? lat_fin : latch));
        filtered_angle <= smoothed;
      end
    end
  end
endmodule
`default_nettype wire

FILE: sv/sapc_ctrl.sv
`default_nettype none
module sapc_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire                    out_stall,
  output sapc_pkg::sapc_cmd_t    cmd,
  input  sapc_pkg::sapc_status_t status
);
  import sapc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SAMPLE, S_SUM, S_CTRL, S_MULT, S_PROD, S_FIN, S_OUT
  } state_t;
  state_t state;

  // The input is taken only when the previous result has left.
  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    cmd = '0;
    cmd.load    = (state == S_IDLE) && in_valid && !out_valid;
    cmd.sample  = (state == S_SAMPLE) && status.sample_valid;
    cmd.average = (state == S_SUM) && status.sample_valid;
    cmd.control = (state == S_CTRL);
    cmd.mult    = (state == S_MULT);
    cmd.finish  = (state == S_PROD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (cmd.load) state <= S_SAMPLE;
        S_SAMPLE: state <= S_SUM;
        S_SUM: if (!status.sample_valid || status.sum_done) state <= S_CTRL;
        S_CTRL: state <= S_MULT;
        S_MULT: state <= S_PROD;
        S_PROD: state <= S_FIN;
        S_FIN: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/swing_axis_position_controller.sv
`default_nettype none
// Swing axis position controller. One control tick is taken per input transfer and
// gives one result transfer. The result is offered after the sample, sum, control,
// multiply, product, finish and output states; when the tick carries an encoder sample,
// the sum state walks the history one entry per cycle and then registers the average.
// The next tick is taken the cycle after the result has been transferred, so the block
// never takes a new tick before it is through with the last one.
// Configuration writes are always ready and must come only while the block is idle.
module swing_axis_position_controller #(
  parameter int unsigned FILTER_DEPTH = 5,
  parameter int unsigned DWELL_MS     = 1000
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [7:0]  mode,
  input  wire [16:0]        swing_target,
  input  wire               halt,
  input  wire               sample_valid,
  input  wire [11:0]        encoder_raw,
  input  wire [31:0]        now_ms,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [21:0] swing_speed,
  output logic              at_target,
  output logic              task_complete,
  output logic [16:0]       filtered_angle,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire               cfg_index,
  input  wire [11:0]        cfg_data
);
  import sapc_pkg::*;

  sapc_cmd_t cmd;
  sapc_status_t status;
  logic [11:0] tolerance;
  logic [8:0] microstep_factor;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 12'd256;
      microstep_factor <= 9'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TOLERANCE: tolerance <= cfg_data;
        CFG_MICROSTEP: microstep_factor <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  sapc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .status(status)
  );

  sapc_datapath #(.FILTER_DEPTH(FILTER_DEPTH), .DWELL_MS(DWELL_MS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .tolerance(tolerance), .microstep_factor(microstep_factor),
    .mode(mode), .swing_target(swing_target), .halt(halt),
    .sample_valid(sample_valid), .encoder_raw(encoder_raw), .now_ms(now_ms),
    .swing_speed(swing_speed), .at_target(at_target),
    .task_complete(task_complete), .filtered_angle(filtered_angle)
  );
endmodule
`default_nettype wire

FILE: sv/sapc_checker.sv
`default_nettype none
module sapc_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_stall,
  input wire out_valid,
  input wire out_stall,
  input wire signed [21:0] swing_speed,
  input wire [16:0] filtered_angle
);
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(swing_speed))
    else $error("result changed under stall");
  // No new item is taken while a result waits.
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken with result pending");
  // An accepted item cannot give its result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid) else $error("result too early");
  // The average stays within one turn.
  a_rng: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> filtered_angle < 17'd92160) else $error("angle out of range");
endmodule

bind swing_axis_position_controller sapc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .swing_speed(swing_speed), .filtered_angle(filtered_angle)
);
`default_nettype wire
